FILE: rtl/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types and constants of the chained range offset remap unit.
// ----------------------------------------------------------------------------
package crm_pkg;

  // default table geometry
  localparam int STAGES_DEF          = 8;
  localparam int RULES_PER_STAGE_DEF = 8;

  // field widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 4;
  localparam int NEFF_W  = 5;

  localparam logic [CFG_W-1:0] STAGES_IN_USE_RST = 4'd7;

  // operation codes on the input channel
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_XLATE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified item kinds held in the queue
  typedef enum logic [1:0] {
    K_WRITE,
    K_XLATE,
    K_CLEAR
  } kind_t;

  // one rule as held in the table: match low <= v < rule_end
  typedef struct packed {
    logic [VAL_W-1:0]        low;
    logic [VAL_W:0]          rule_end;
    logic signed [VAL_W:0]   offset;
  } rule_t;

  // queue entry; value is the rule's source low or the query
  typedef struct packed {
    kind_t                   kind;
    logic [IDX_W-1:0]        stage;
    logic [IDX_W-1:0]        slot;
    logic [VAL_W-1:0]        value;
    logic [VAL_W:0]          rule_end;
    logic signed [VAL_W:0]   offset;
  } item_t;

  // table write request from the back end
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] stage;
    logic [IDX_W-1:0] slot;
    rule_t            rule;
  } tbl_wr_t;

  // back end walk states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FINISH
  } bk_state_t;

endpackage

FILE: rtl/chained_range_offset_remap_unit.sv
// ----------------------------------------------------------------------------
// chained_range_offset_remap_unit
// Multi-stage range table translation with running minimum.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle into a two-entry queue while the
// queue has room; operation 3 and rule writes outside the table are dropped
// there. The back end executes a rule write or a minimum clear from its idle
// state. A translation in the back end walks N stages, N being stages_in_use
// clamped to STAGES: the idle state that takes the query fetches the first
// stage row, the walk then handles the stages in turn (all slots of a stage
// compared in parallel on a registered row read of the rule table), and the
// finish state loads the output register once the output is free. No
// clearing pass is needed after reset; rule valid bits are cleared at once.
// ----------------------------------------------------------------------------
module chained_range_offset_remap_unit #(
  parameter int STAGES          = crm_pkg::STAGES_DEF,
  parameter int RULES_PER_STAGE = crm_pkg::RULES_PER_STAGE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [crm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [crm_pkg::OP_W-1:0]   operation,
  input  logic [crm_pkg::IDX_W-1:0]  stage,
  input  logic [crm_pkg::IDX_W-1:0]  slot,
  input  logic [crm_pkg::VAL_W-1:0]  dest_start,
  input  logic [crm_pkg::VAL_W-1:0]  src_start,
  input  logic [crm_pkg::VAL_W-1:0]  range_length,
  input  logic [crm_pkg::VAL_W-1:0]  query_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [crm_pkg::VAL_W-1:0]  translated,
  output logic [crm_pkg::VAL_W-1:0]  running_minimum
);
  import crm_pkg::*;

  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

  logic [CFG_W-1:0]           stages_in_use;
  logic                       q_full;
  logic                       q_push;
  item_t                      q_in;
  logic                       q_pop;
  logic                       q_valid;
  item_t                      q_head;
  tbl_wr_t                    tbl_wr;
  logic [SW-1:0]              rd_addr;
  rule_t                      rd_rules [RULES_PER_STAGE];
  logic [RULES_PER_STAGE-1:0] rd_valid;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      stages_in_use <= STAGES_IN_USE_RST;
    end else if (cfg_we) begin
      stages_in_use <= cfg_wdata;
    end
  end

  crm_front #(
    .STAGES          (STAGES),
    .RULES_PER_STAGE (RULES_PER_STAGE)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .stage        (stage),
    .slot         (slot),
    .dest_start   (dest_start),
    .src_start    (src_start),
    .range_length (range_length),
    .query_value  (query_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  crm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  crm_rule_table #(
    .STAGES          (STAGES),
    .RULES_PER_STAGE (RULES_PER_STAGE),
    .SW              (SW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_addr  (rd_addr),
    .rd_rules (rd_rules),
    .rd_valid (rd_valid)
  );

  crm_back #(
    .STAGES          (STAGES),
    .RULES_PER_STAGE (RULES_PER_STAGE),
    .SW              (SW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .stages_in_use   (stages_in_use),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .tbl_wr          (tbl_wr),
    .rd_addr         (rd_addr),
    .rd_rules        (rd_rules),
    .rd_valid        (rd_valid),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .translated      (translated),
    .running_minimum (running_minimum)
  );

endmodule

FILE: rtl/crm_front.sv
// ----------------------------------------------------------------------------
// crm_front
// Accepts input items, drops those with no effect, precomputes rule bounds
// and offsets, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module crm_front #(
  parameter int STAGES          = crm_pkg::STAGES_DEF,
  parameter int RULES_PER_STAGE = crm_pkg::RULES_PER_STAGE_DEF
) (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [crm_pkg::OP_W-1:0]   operation,
  input  logic [crm_pkg::IDX_W-1:0]  stage,
  input  logic [crm_pkg::IDX_W-1:0]  slot,
  input  logic [crm_pkg::VAL_W-1:0]  dest_start,
  input  logic [crm_pkg::VAL_W-1:0]  src_start,
  input  logic [crm_pkg::VAL_W-1:0]  range_length,
  input  logic [crm_pkg::VAL_W-1:0]  query_value,
  input  logic                       q_full,
  output logic                       q_push,
  output crm_pkg::item_t             q_item
);
  import crm_pkg::*;

  logic  keep;
  logic  in_table;
  kind_t kind;

  // a write outside the table geometry is dropped
  assign in_table = (32'(stage) < STAGES) && (32'(slot) < RULES_PER_STAGE);

  // classify
  always_comb begin
    kind = K_XLATE;
    keep = 1'b0;
    unique case (operation)
      OP_WRITE: begin
        kind = K_WRITE;
        keep = in_table;
      end
      OP_XLATE: begin
        kind = K_XLATE;
        keep = 1'b1;
      end
      OP_CLEAR: begin
        kind = K_CLEAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // payload: source end is exclusive, offset is destination minus source
  always_comb begin
    q_item.kind     = kind;
    q_item.stage    = stage;
    q_item.slot     = slot;
    q_item.value    = (operation == OP_WRITE) ? src_start : query_value;
    q_item.rule_end = {1'b0, src_start} + {1'b0, range_length};
    q_item.offset   = $signed({1'b0, dest_start}) - $signed({1'b0, src_start});
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

FILE: rtl/crm_queue.sv
// ----------------------------------------------------------------------------
// crm_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module crm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crm_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output crm_pkg::item_t  head
);
  import crm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= CW'(count + 1'b1);
        2'b01:   count <= CW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> count == CW'(QUEUE_DEPTH))
    else $error("full queue lost an entry");

  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == CW'($past(count) - 1'b1))
    else $error("pop did not lower fill level");

endmodule

FILE: rtl/crm_rule_table.sv
// ----------------------------------------------------------------------------
// crm_rule_table
// Rule store: one memory per slot lane, one row per stage, so a whole stage
// is read as one row. Valid bits sit in flops and are cleared on reset.
// ----------------------------------------------------------------------------
module crm_rule_table #(
  parameter int STAGES          = crm_pkg::STAGES_DEF,
  parameter int RULES_PER_STAGE = crm_pkg::RULES_PER_STAGE_DEF,
  parameter int SW              = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  crm_pkg::tbl_wr_t            wr,
  input  logic [SW-1:0]               rd_addr,
  output crm_pkg::rule_t              rd_rules [RULES_PER_STAGE],
  output logic [RULES_PER_STAGE-1:0]  rd_valid
);
  import crm_pkg::*;

  logic [RULES_PER_STAGE-1:0] valid [STAGES];
  logic [SW-1:0]              wr_row;

  assign wr_row = SW'(wr.stage);

  // per-lane rule memories with registered read
  for (genvar lane = 0; lane < RULES_PER_STAGE; lane++) begin : g_lane
    rule_t mem [STAGES];

    always_ff @(posedge clk) begin
      if (wr.en && (32'(wr.slot) == lane)) begin
        mem[wr_row] <= wr.rule;
      end
      rd_rules[lane] <= mem[rd_addr];
    end
  end

  // valid bits, read alongside the row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        valid[s] <= '0;
      end
    end else if (wr.en) begin
      for (int k = 0; k < RULES_PER_STAGE; k++) begin
        if (32'(wr.slot) == k) begin
          valid[wr_row][k] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_addr];
  end

endmodule

FILE: rtl/crm_back.sv
// ----------------------------------------------------------------------------
// crm_back
// Executes queued items: rule writes, minimum clears, and translations that
// walk the stages one per cycle, then holds the result for the output.
// ----------------------------------------------------------------------------
module crm_back #(
  parameter int STAGES          = crm_pkg::STAGES_DEF,
  parameter int RULES_PER_STAGE = crm_pkg::RULES_PER_STAGE_DEF,
  parameter int SW              = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [crm_pkg::CFG_W-1:0]   stages_in_use,
  input  logic                        q_valid,
  input  crm_pkg::item_t              q_item,
  output logic                        q_pop,
  output crm_pkg::tbl_wr_t            tbl_wr,
  output logic [SW-1:0]               rd_addr,
  input  crm_pkg::rule_t              rd_rules [RULES_PER_STAGE],
  input  logic [RULES_PER_STAGE-1:0]  rd_valid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crm_pkg::VAL_W-1:0]   translated,
  output logic [crm_pkg::VAL_W-1:0]   running_minimum
);
  import crm_pkg::*;

  bk_state_t          state;
  bk_state_t          state_next;
  logic [VAL_W-1:0]   v;
  logic [VAL_W-1:0]   least;
  logic [SW-1:0]      cnt;
  logic [SW-1:0]      last;
  logic [NEFF_W-1:0]  n_eff;
  logic               start_xlate;
  logic               do_clear;
  logic               deliver;
  logic               wr_en;
  logic [VAL_W-1:0]   stage_result;
  logic [VAL_W-1:0]   new_min;

  // stage count clamped to the table
  assign n_eff = (NEFF_W'(stages_in_use) > NEFF_W'(STAGES)) ?
                 NEFF_W'(STAGES) : NEFF_W'(stages_in_use);

  // one stage: parallel range match, lowest slot wins, add and saturate
  always_comb begin
    logic                hit;
    logic signed [VAL_W:0] sel_off;
    logic signed [VAL_W+1:0] sum;
    hit     = 1'b0;
    sel_off = '0;
    for (int k = RULES_PER_STAGE - 1; k >= 0; k--) begin
      if (rd_valid[k] && (v >= rd_rules[k].low) &&
          ({1'b0, v} < rd_rules[k].rule_end)) begin
        hit     = 1'b1;
        sel_off = rd_rules[k].offset;
      end
    end
    sum = $signed({2'b00, v}) + $signed({sel_off[VAL_W], sel_off});
    if (!hit) begin
      stage_result = v;
    end else if (sum[VAL_W+1]) begin
      stage_result = '0;
    end else if (sum[VAL_W]) begin
      stage_result = '1;
    end else begin
      stage_result = sum[VAL_W-1:0];
    end
  end

  assign new_min = (v < least) ? v : least;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_item.kind == K_XLATE) begin
          state_next = (n_eff == '0) ? BK_FINISH : BK_WALK;
        end
      end
      BK_WALK: begin
        if (cnt == last) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop       = 1'b0;
    start_xlate = 1'b0;
    do_clear    = 1'b0;
    deliver     = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop       = q_valid;
        wr_en       = q_valid && (q_item.kind == K_WRITE);
        start_xlate = q_valid && (q_item.kind == K_XLATE);
        do_clear    = q_valid && (q_item.kind == K_CLEAR);
      end
      BK_WALK: begin
        rd_addr = SW'(cnt + 1'b1);
      end
      BK_FINISH: begin
        deliver = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign tbl_wr.en            = wr_en;
  assign tbl_wr.stage         = q_item.stage;
  assign tbl_wr.slot          = q_item.slot;
  assign tbl_wr.rule.low      = q_item.value;
  assign tbl_wr.rule.rule_end = q_item.rule_end;
  assign tbl_wr.rule.offset   = q_item.offset;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      least     <= '1;
    end else begin
      state <= state_next;
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_clear) begin
        least <= '1;
      end else if (deliver) begin
        least <= new_min;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start_xlate) begin
      v    <= q_item.value;
      cnt  <= '0;
      last <= SW'(n_eff - 1'b1);
    end else if (state == BK_WALK) begin
      v   <= stage_result;
      cnt <= SW'(cnt + 1'b1);
    end
    if (deliver) begin
      translated      <= v;
      running_minimum <= new_min;
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK |-> cnt <= last)
    else $error("stage counter passed the last stage");

  a_min_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_minimum <= translated)
    else $error("running minimum above translated value");

  a_min_tracks: assert property (@(posedge clk) disable iff (rst)
    deliver |=> out_valid && running_minimum == least)
    else $error("held minimum differs from delivered minimum");

endmodule
